// ----- rtl/lsc_pkg.sv -----
// Shared types, codes and a helper function for the indexed list store.
package lsc_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VAL_W        = 32;
  localparam int LEN_W        = 7;
  localparam int POS_W        = 7;
  localparam int ACT_W        = 4;
  localparam int TREE_FANIN   = 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD_FRONT = 4'd0,
    ACT_ADD_END   = 4'd1,
    ACT_ADD_AT    = 4'd2,
    ACT_GET_FRONT = 4'd3,
    ACT_GET_END   = 4'd4,
    ACT_GET_AT    = 4'd5,
    ACT_REM_FRONT = 4'd6,
    ACT_REM_END   = 4'd7,
    ACT_REM_AT    = 4'd8,
    ACT_SORT      = 4'd9
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_SORT
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TREE,
    ST_SORT
  } state_t;

  typedef struct packed {
    cell_op_t op;
    logic     rd_en;
    logic     odd;
  } cell_ctrl_t;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] payload;
  } in_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [LEN_W-1:0]        length;
    logic [1:0]              status;
  } out_rsp_t;

  // Number of registered levels of a reduction tree with fan-in eight over n leaves.
  function automatic int tree_levels(input int n);
    int lv;
    int span;
    lv   = 1;
    span = TREE_FANIN;
    while (span < n) begin
      span = span * TREE_FANIN;
      lv   = lv + 1;
    end
    return lv;
  endfunction

endpackage

// ----- rtl/indexed_list_store_core.sv -----
// Top level of the indexed list store: command decode, cell row, read tree and result register.
//
// The list lives in a row of CAPACITY cells, one entry per cell, front at cell 0. Inserts and
// removes update the row in the cycle the request is accepted; failed commands do not.
// Adds, errors, unused codes and sorts of fewer than two entries give their result in the
// next cycle, so one such request is taken every cycle unless out_stall holds a result. Reads
// and removes that succeed pull the value through a registered OR tree of fan-in eight, L
// levels deep (2 at CAPACITY 64, 4 at 4096), and block new requests until it leaves the tree.
// A sort of n >= 2 entries runs n rounds of odd-even neighbor exchange across the cell row,
// one round per cycle, and holds off requests until done. A new request is taken only when no
// command is in flight and the result register is free or being emptied in the same cycle.
module indexed_list_store_core import lsc_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_rsp_t out_rsp
);

  localparam int IW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int CMPW   = (CW > POS_W) ? CW : POS_W;
  localparam int LEVELS = tree_levels(CAPACITY);

  state_t         state_r;
  state_t         state_nxt;
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  count_nxt;
  logic [CW-1:0]  cnt_r;
  logic [CW-1:0]  cnt_nxt;
  logic           phase_r;
  logic           phase_nxt;
  logic           out_valid_r;
  logic           out_valid_nxt;
  out_rsp_t       out_r;
  out_rsp_t       rsp_nxt;
  logic           emit;
  logic           in_acc;

  cell_op_t       dec_op;
  logic [IW-1:0]  dec_idx;
  logic           dec_rd;
  status_t        dec_status;
  logic [CW-1:0]  dec_cnt;
  logic           dec_wait;
  logic           dec_sort;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic           is_full;
  logic           is_empty;

  cell_ctrl_t              ctrl;
  logic signed [VAL_W-1:0] cell_q   [CAPACITY];
  logic signed [VAL_W-1:0] cell_sel [CAPACITY];
  logic [CAPACITY-1:0]     swap;
  logic signed [VAL_W-1:0] tree_top;

  assign in_stall  = !((state_r == ST_IDLE) && (!out_valid_r || !out_stall));
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  assign pos_ext  = CMPW'(in_req.position);
  assign cnt_ext  = CMPW'(count_r);
  assign is_full  = (count_r == CW'(CAPACITY));
  assign is_empty = (count_r == '0);

  always_comb begin
    dec_op     = CELL_HOLD;
    dec_idx    = '0;
    dec_rd     = 1'b0;
    dec_status = STAT_OK;
    dec_cnt    = count_r;
    dec_wait   = 1'b0;
    dec_sort   = 1'b0;
    unique case (in_req.action)
      ACT_ADD_FRONT, ACT_ADD_END, ACT_ADD_AT: begin
        if (is_full) begin
          dec_status = STAT_FULL;
        end else if ((in_req.action == ACT_ADD_AT) && (pos_ext > cnt_ext)) begin
          dec_status = STAT_RANGE;
        end else begin
          dec_op  = CELL_INSERT;
          dec_cnt = count_r + CW'(1);
          if (in_req.action == ACT_ADD_END) begin
            dec_idx = IW'(count_r);
          end else if (in_req.action == ACT_ADD_AT) begin
            dec_idx = IW'(in_req.position);
          end
        end
      end
      ACT_GET_FRONT, ACT_GET_END, ACT_GET_AT,
      ACT_REM_FRONT, ACT_REM_END, ACT_REM_AT: begin
        if (is_empty) begin
          dec_status = STAT_EMPTY;
        end else if (((in_req.action == ACT_GET_AT) || (in_req.action == ACT_REM_AT)) &&
                     (pos_ext >= cnt_ext)) begin
          dec_status = STAT_RANGE;
        end else begin
          dec_rd   = 1'b1;
          dec_wait = 1'b1;
          if ((in_req.action == ACT_GET_END) || (in_req.action == ACT_REM_END)) begin
            dec_idx = IW'(count_r - CW'(1));
          end else if ((in_req.action == ACT_GET_AT) || (in_req.action == ACT_REM_AT)) begin
            dec_idx = IW'(in_req.position);
          end
          if ((in_req.action == ACT_REM_FRONT) || (in_req.action == ACT_REM_END) ||
              (in_req.action == ACT_REM_AT)) begin
            dec_op  = CELL_REMOVE;
            dec_cnt = count_r - CW'(1);
          end
        end
      end
      ACT_SORT: begin
        if (count_r >= CW'(2)) begin
          dec_sort = 1'b1;
        end
      end
      default: begin
        dec_op = CELL_HOLD;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && dec_wait) begin
          state_nxt = ST_TREE;
        end else if (in_acc && dec_sort) begin
          state_nxt = ST_SORT;
        end
      end
      ST_TREE, ST_SORT: begin
        if (cnt_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl          = '{op: CELL_HOLD, rd_en: 1'b0, odd: phase_r};
    emit          = 1'b0;
    rsp_nxt       = '{value: '0, length: LEN_W'(count_r), status: STAT_OK};
    count_nxt     = count_r;
    cnt_nxt       = (cnt_r == '0) ? cnt_r : cnt_r - CW'(1);
    phase_nxt     = phase_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ctrl.op        = dec_op;
          ctrl.rd_en     = dec_rd;
          emit           = !dec_wait && !dec_sort;
          count_nxt      = dec_cnt;
          rsp_nxt.length = LEN_W'(dec_cnt);
          rsp_nxt.status = dec_status;
          cnt_nxt        = dec_wait ? CW'(LEVELS - 1) : count_r - CW'(1);
          phase_nxt      = 1'b0;
        end
      end
      ST_TREE: begin
        emit          = (cnt_r == '0);
        rsp_nxt.value = tree_top;
      end
      ST_SORT: begin
        ctrl.op   = CELL_SORT;
        emit      = (cnt_r == '0);
        phase_nxt = !phase_r;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    out_valid_nxt = emit || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cnt_r       <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cnt_r       <= cnt_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= rsp_nxt;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_d;
    logic signed [VAL_W-1:0] right_d;
    logic                    swap_l;
    if (i == 0) begin : g_first
      assign left_d = '0;
      assign swap_l = 1'b0;
    end else begin : g_mid
      assign left_d = cell_q[i-1];
      assign swap_l = swap[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cell_q[i+1];
    end
    lsc_cell #(
      .IDX (i),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (dec_idx),
      .count      (count_r),
      .payload    (in_req.payload),
      .left_data  (left_d),
      .right_data (right_d),
      .swap_in    (swap_l),
      .swap_out   (swap[i]),
      .data       (cell_q[i]),
      .sel_data   (cell_sel[i])
    );
  end

  lsc_tree #(
    .N      (CAPACITY),
    .LEVELS (LEVELS)
  ) u_tree (
    .clk  (clk),
    .leaf (cell_sel),
    .top  (tree_top)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_busy_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !out_valid_r)
    else $error("result register occupied while a command is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !emit)
    else $error("pending result overwritten");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (dec_op == CELL_REMOVE) |=> count_r == $past(count_r) - CW'(1))
    else $error("remove did not decrement the entry count");

endmodule

// ----- rtl/lsc_cell.sv -----
// One storage cell of the list: holds one entry and trades it with its neighbors.
module lsc_cell import lsc_pkg::*; #(
  parameter int IDX = 0,
  parameter int IW  = 6,
  parameter int CW  = 7
) (
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic [IW-1:0]           idx,
  input  logic [CW-1:0]           count,
  input  logic signed [VAL_W-1:0] payload,
  input  logic signed [VAL_W-1:0] left_data,
  input  logic signed [VAL_W-1:0] right_data,
  input  logic                    swap_in,
  output logic                    swap_out,
  output logic signed [VAL_W-1:0] data,
  output logic signed [VAL_W-1:0] sel_data
);

  localparam logic IS_ODD = logic'(IDX % 2);

  logic signed [VAL_W-1:0] data_r;
  logic signed [VAL_W-1:0] data_nxt;
  logic                    pair_live;

  assign pair_live = (count > CW'(IDX + 1)) && (ctrl.odd == IS_ODD);
  assign swap_out  = (ctrl.op == CELL_SORT) && pair_live && (right_data < data_r);
  assign data      = data_r;
  assign sel_data  = (ctrl.rd_en && (idx == IW'(IDX))) ? data_r : '0;

  always_comb begin
    data_nxt = data_r;
    unique case (ctrl.op)
      CELL_HOLD: begin
        data_nxt = data_r;
      end
      CELL_INSERT: begin
        if (IW'(IDX) > idx) begin
          data_nxt = left_data;
        end else if (IW'(IDX) == idx) begin
          data_nxt = payload;
        end
      end
      CELL_REMOVE: begin
        if (IW'(IDX) >= idx) begin
          data_nxt = right_data;
        end
      end
      CELL_SORT: begin
        if (swap_out) begin
          data_nxt = right_data;
        end else if (swap_in) begin
          data_nxt = left_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ----- rtl/lsc_tree.sv -----
// Registered OR tree that gathers the one selected cell value.
module lsc_tree import lsc_pkg::*; #(
  parameter int N      = 64,
  parameter int LEVELS = 2
) (
  input  logic                    clk,
  input  logic signed [VAL_W-1:0] leaf [N],
  output logic signed [VAL_W-1:0] top
);

  localparam int LEAVES = TREE_FANIN ** LEVELS;

  logic signed [VAL_W-1:0] leaf_pad [LEAVES];
  logic signed [VAL_W-1:0] node_r   [LEVELS][LEAVES];
  logic signed [VAL_W-1:0] node_nxt [LEVELS][LEAVES];

  always_comb begin
    for (int j = 0; j < LEAVES; j++) begin
      leaf_pad[j] = (j < N) ? leaf[j] : '0;
    end
  end

  always_comb begin
    for (int k = 0; k < LEVELS; k++) begin
      for (int j = 0; j < LEAVES; j++) begin
        node_nxt[k][j] = '0;
      end
    end
    for (int j = 0; j < LEAVES / TREE_FANIN; j++) begin
      for (int m = 0; m < TREE_FANIN; m++) begin
        node_nxt[0][j] = node_nxt[0][j] | leaf_pad[TREE_FANIN * j + m];
      end
    end
    for (int k = 1; k < LEVELS; k++) begin
      for (int j = 0; j < LEAVES; j++) begin
        if (j < (LEAVES >> (3 * (k + 1)))) begin
          for (int m = 0; m < TREE_FANIN; m++) begin
            node_nxt[k][j] = node_nxt[k][j] | node_r[k-1][TREE_FANIN * j + m];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
  end

  assign top = node_r[LEVELS-1][0];

endmodule

// ----- tb/indexed_list_store_core_tb.sv -----
// Self-checking testbench for the indexed list store core: directed, random and stall tests.
module indexed_list_store_core_tb;
  import lsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP          = CAPACITY_DEF;
  localparam int LIMIT_CYCLES = 800000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_stall;
  out_rsp_t out_rsp;

  logic signed [VAL_W-1:0] list_cells [CAP];
  int                      list_count;
  out_rsp_t                rsp_expect_q [$];
  out_rsp_t                rsp_head;
  int                      fail_count;
  int                      cycle_count;
  int                      tx_gap_max;
  int                      rx_gap_max;
  int                      rx_stall_left;
  int                      rx_hold_cycles;

  indexed_list_store_core #(.CAPACITY(CAP)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rsp  (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("indexed_list_store_core_tb: FAIL");
      $finish;
    end
  end

  // Applies one request to the local copy of the list and returns the result it must produce.
  function automatic out_rsp_t predict_list_cmd(in_req_t req);
    out_rsp_t                rsp;
    int                      idx;
    int                      j;
    logic signed [VAL_W-1:0] key;
    rsp        = '0;
    rsp.status = STAT_OK;
    case (req.action)
      ACT_ADD_FRONT, ACT_ADD_END, ACT_ADD_AT: begin
        if (list_count >= CAP) begin
          rsp.status = STAT_FULL;
        end else begin
          if (req.action == ACT_ADD_FRONT) begin
            idx = 0;
          end else if (req.action == ACT_ADD_END) begin
            idx = list_count;
          end else begin
            idx = int'(req.position);
          end
          if (idx > list_count) begin
            rsp.status = STAT_RANGE;
          end else begin
            for (j = list_count; j > idx; j--) list_cells[j] = list_cells[j-1];
            list_cells[idx] = req.payload;
            list_count++;
          end
        end
      end
      ACT_GET_FRONT, ACT_GET_END, ACT_GET_AT, ACT_REM_FRONT, ACT_REM_END, ACT_REM_AT: begin
        if (list_count == 0) begin
          rsp.status = STAT_EMPTY;
        end else begin
          if (req.action == ACT_GET_FRONT || req.action == ACT_REM_FRONT) begin
            idx = 0;
          end else if (req.action == ACT_GET_END || req.action == ACT_REM_END) begin
            idx = list_count - 1;
          end else begin
            idx = int'(req.position);
          end
          if (idx >= list_count) begin
            rsp.status = STAT_RANGE;
          end else begin
            rsp.value = list_cells[idx];
            if (req.action == ACT_REM_FRONT || req.action == ACT_REM_END ||
                req.action == ACT_REM_AT) begin
              for (j = idx; j + 1 < list_count; j++) list_cells[j] = list_cells[j+1];
              list_count--;
            end
          end
        end
      end
      ACT_SORT: begin
        for (idx = 1; idx < list_count; idx++) begin
          key = list_cells[idx];
          j   = idx;
          while (j > 0 && key < list_cells[j-1]) begin
            list_cells[j] = list_cells[j-1];
            j--;
          end
          list_cells[j] = key;
        end
      end
      default: begin
      end
    endcase
    rsp.length = LEN_W'(list_count);
    return rsp;
  endfunction

  task automatic send_req(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                          input logic signed [VAL_W-1:0] val);
    in_req_t req;
    int      gap;
    req.action   = act;
    req.position = pos;
    req.payload  = val;
    gap          = $urandom_range(0, tx_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
    rsp_expect_q.push_back(predict_list_cmd(req));
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_payload();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7) - 3;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 32'sh0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position(input int span);
    if ($urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, 127));
    return POS_W'($urandom_range(0, span));
  endfunction

  // Receiver: a long hold when one is requested, else a random stall after each result.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_stall      <= 1'b1;
        rx_hold_cycles <= rx_hold_cycles - 1;
      end else if (rx_stall_left > 0) begin
        out_stall     <= 1'b1;
        rx_stall_left <= rx_stall_left - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (rsp_expect_q.size() == 0) begin
        $error("unexpected result: value %0d length %0d status %0d",
               out_rsp.value, out_rsp.length, out_rsp.status);
        fail_count++;
      end else begin
        rsp_head = rsp_expect_q.pop_front();
        if (out_rsp.value !== rsp_head.value) begin
          $error("value: expected %0d, got %0d", rsp_head.value, out_rsp.value);
          fail_count++;
        end
        if (out_rsp.length !== rsp_head.length) begin
          $error("length: expected %0d, got %0d", rsp_head.length, out_rsp.length);
          fail_count++;
        end
        if (out_rsp.status !== rsp_head.status) begin
          $error("status: expected %0d, got %0d", rsp_head.status, out_rsp.status);
          fail_count++;
        end
      end
      rx_stall_left <= $urandom_range(0, rx_gap_max);
    end
  end

  task automatic test_empty_list();
    send_req(ACT_GET_FRONT, '0, '0);
    send_req(ACT_GET_END, '0, '0);
    send_req(ACT_GET_AT, '0, '0);
    send_req(ACT_REM_FRONT, '0, '0);
    send_req(ACT_REM_END, '0, '0);
    send_req(ACT_REM_AT, '0, '0);
    send_req(ACT_SORT, '0, '0);
    send_req(4'd10, 7'd5, 32'sh12345678);
    send_req(4'd15, 7'd127, -32'sd1);
    send_req(ACT_ADD_AT, 7'd1, 32'sd9);
    go_idle();
  endtask

  task automatic test_edge_values();
    send_req(ACT_ADD_AT, 7'd0, 32'sh7fffffff);
    send_req(ACT_ADD_FRONT, '0, 32'sh80000000);
    send_req(ACT_ADD_END, '0, -32'sd1);
    send_req(ACT_ADD_AT, 7'd3, 32'sd1);
    send_req(ACT_ADD_AT, 7'd5, 32'sd2);
    send_req(ACT_GET_FRONT, '0, '0);
    send_req(ACT_GET_END, '0, '0);
    send_req(ACT_GET_AT, 7'd2, '0);
    send_req(ACT_GET_AT, 7'd4, '0);
    send_req(ACT_GET_AT, 7'd127, '0);
    send_req(ACT_SORT, '0, '0);
    send_req(ACT_GET_AT, 7'd0, '0);
    send_req(ACT_GET_AT, 7'd3, '0);
    send_req(ACT_REM_AT, 7'd1, '0);
    send_req(ACT_REM_AT, 7'd127, '0);
    send_req(ACT_REM_END, '0, '0);
    send_req(ACT_REM_FRONT, '0, '0);
    go_idle();
  endtask

  // Fills the list to capacity, overflows it, sorts a full list with duplicates and drains it.
  task automatic test_full_list();
    logic [ACT_W-1:0] act;
    tx_gap_max = 14;
    rx_gap_max = 14;
    while (list_count < CAP) begin
      act = ACT_W'($urandom_range(0, 2));
      send_req(act, POS_W'($urandom_range(0, list_count)),
               ($urandom_range(0, 3) == 0) ? pick_payload() : $urandom_range(0, 15) - 8);
    end
    send_req(ACT_ADD_FRONT, '0, 32'sd1);
    send_req(ACT_ADD_END, '0, 32'sd1);
    send_req(ACT_ADD_AT, 7'd127, 32'sd1);
    send_req(ACT_GET_AT, 7'd64, '0);
    send_req(ACT_SORT, '0, '0);
    while (list_count > 0) begin
      act = ACT_W'($urandom_range(ACT_REM_FRONT, ACT_REM_AT));
      send_req(act, POS_W'($urandom_range(0, list_count - 1)), '0);
    end
    send_req(ACT_REM_AT, '0, '0);
    go_idle();
  endtask

  task automatic test_random_mix();
    int               ph;
    int               n;
    int               r;
    int               add_pct;
    logic [ACT_W-1:0] act;
    for (ph = 0; ph < 12; ph++) begin
      tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
      rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
      case ($urandom_range(0, 2))
        0: add_pct = 60;
        1: add_pct = 15;
        default: add_pct = 35;
      endcase
      for (n = 0; n < 150; n++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          act = ACT_W'($urandom_range(10, 15));
        end else if (r < 6) begin
          act = ACT_SORT;
        end else if (r < 6 + add_pct) begin
          act = ACT_W'($urandom_range(ACT_ADD_FRONT, ACT_ADD_AT));
        end else if (r < 31 + add_pct) begin
          act = ACT_W'($urandom_range(ACT_GET_FRONT, ACT_GET_AT));
        end else begin
          act = ACT_W'($urandom_range(ACT_REM_FRONT, ACT_REM_AT));
        end
        send_req(act, pick_position(list_count), pick_payload());
      end
    end
    go_idle();
  endtask

  task automatic test_output_stall();
    int n;
    tx_gap_max     = 0;
    rx_gap_max     = 0;
    rx_hold_cycles = 200;
    for (n = 0; n < 40; n++) begin
      send_req(ACT_W'($urandom_range(ACT_ADD_FRONT, ACT_REM_AT)),
               pick_position(list_count), pick_payload());
    end
    go_idle();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req         = '0;
    list_count     = 0;
    fail_count     = 0;
    cycle_count    = 0;
    tx_gap_max     = 0;
    rx_gap_max     = 0;
    rx_stall_left  = 0;
    rx_hold_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    tx_gap_max = 14;
    rx_gap_max = 14;
    test_edge_values();
    test_full_list();
    test_random_mix();
    test_output_stall();

    while (rsp_expect_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("indexed_list_store_core_tb: PASS");
    end else begin
      $display("indexed_list_store_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/lsc_pkg.sv
rtl/lsc_cell.sv
rtl/lsc_tree.sv
rtl/indexed_list_store_core.sv
tb/indexed_list_store_core_tb.sv
